@@ rtl/pmu_pkg.sv @@
// Shared constants and types for the paged memory unit.
`default_nettype none
package pmu_pkg;
	localparam int NUM_FRAMES_DEF = 64;
	localparam int NUM_PROC_DEF = 8;
	localparam int PAGE_NUM_W = 10;
	localparam int PAGE_OFF_W = 12;
	localparam int PAGES = 1 << PAGE_NUM_W;

	localparam logic [2:0] CMD_READ = 3'd0;
	localparam logic [2:0] CMD_WRITE = 3'd1;
	localparam logic [2:0] CMD_ALLOC = 3'd2;
	localparam logic [2:0] CMD_DEALLOC = 3'd3;
	localparam logic [2:0] CMD_EXIT = 3'd4;

	localparam int PTE_PRESENT_BIT = 3;
	localparam int PTE_WRITE_BIT = 1;
	localparam logic [7:0] RD_FAULT_BYTE = 8'd32;
	localparam logic [6:0] FIRST_FRAME_RST = 7'd16;

	typedef struct packed {
		logic pt_we;
		logic fo_we;
		logic bs_we;
	} mem_we_t;
endpackage
`default_nettype wire

@@ rtl/paged_memory_unit_with_frame_allocator_core.sv @@
// Top level of the paged memory unit with its first-free frame allocator.
//
// Channel   Direction  Signals
// command   in         start, busy, cmd, pid, vaddr, wdata, page_count, flags
// result    out        done, rdata, fault
// config    in         cfg_valid, cfg_ready, cfg_data
//
// A read does the table lookup and then the store read; a write does its store access in the lookup state.
// Allocate and deallocate work page by page; allocate scans the frame owner map for a free frame per page.
// A fault or exit adds a teardown that clears the process's page table and frees every frame it owns.
// After reset the memories are cleared before the unit leaves its busy state.
// The result strobe lasts one cycle and cannot be stalled.
`default_nettype none
module paged_memory_unit_with_frame_allocator_core import pmu_pkg::*; #(
	parameter int NUM_FRAMES_TOTAL = NUM_FRAMES_DEF,
	parameter int NUM_PROCESSES = NUM_PROC_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [2:0] cmd,
	input wire logic [2:0] pid,
	input wire logic [21:0] vaddr,
	input wire logic [7:0] wdata,
	input wire logic [10:0] page_count,
	input wire logic [2:0] flags,
	output logic done,
	output logic [7:0] rdata,
	output logic fault,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [6:0] cfg_data
);
	localparam int FW = $clog2(NUM_FRAMES_TOTAL);
	localparam int PIDW = $clog2(NUM_PROCESSES);

	logic [6:0] first_frame_q;
	mem_we_t we;
	logic [PIDW+PAGE_NUM_W-1:0] pt_addr;
	logic [FW+3:0] pt_wdata, pt_rdata;
	logic [FW-1:0] fo_addr;
	logic [2:0] fo_wdata, fo_rdata;
	logic [FW+PAGE_OFF_W-1:0] bs_addr;
	logic [7:0] bs_wdata, bs_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_frame_q <= FIRST_FRAME_RST;
		end else if (cfg_valid && cfg_ready) begin
			first_frame_q <= cfg_data;
		end
	end

	pmu_seq #(
		.NUM_FRAMES_TOTAL(NUM_FRAMES_TOTAL),
		.NUM_PROCESSES(NUM_PROCESSES)
	) u_seq (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .pid(pid), .vaddr(vaddr), .wdata(wdata),
		.page_count(page_count), .flags(flags), .first_frame(first_frame_q),
		.done(done), .rdata(rdata), .fault(fault), .we(we),
		.pt_addr(pt_addr), .pt_wdata(pt_wdata), .pt_rdata(pt_rdata),
		.fo_addr(fo_addr), .fo_wdata(fo_wdata), .fo_rdata(fo_rdata),
		.bs_addr(bs_addr), .bs_wdata(bs_wdata), .bs_rdata(bs_rdata)
	);

	pmu_mem #(
		.NUM_FRAMES_TOTAL(NUM_FRAMES_TOTAL),
		.NUM_PROCESSES(NUM_PROCESSES)
	) u_mem (
		.clk(clk), .we(we),
		.pt_addr(pt_addr), .pt_wdata(pt_wdata), .pt_rdata(pt_rdata),
		.fo_addr(fo_addr), .fo_wdata(fo_wdata), .fo_rdata(fo_rdata),
		.bs_addr(bs_addr), .bs_wdata(bs_wdata), .bs_rdata(bs_rdata)
	);
endmodule
`default_nettype wire

@@ rtl/pmu_mem.sv @@
// Page table, frame owner map and byte store memories.
`default_nettype none
module pmu_mem import pmu_pkg::*; #(
	parameter int NUM_FRAMES_TOTAL = NUM_FRAMES_DEF,
	parameter int NUM_PROCESSES = NUM_PROC_DEF
) (
	input wire logic clk,
	input wire mem_we_t we,
	input wire logic [$clog2(NUM_PROCESSES)+PAGE_NUM_W-1:0] pt_addr,
	input wire logic [$clog2(NUM_FRAMES_TOTAL)+3:0] pt_wdata,
	output logic [$clog2(NUM_FRAMES_TOTAL)+3:0] pt_rdata,
	input wire logic [$clog2(NUM_FRAMES_TOTAL)-1:0] fo_addr,
	input wire logic [2:0] fo_wdata,
	output logic [2:0] fo_rdata,
	input wire logic [$clog2(NUM_FRAMES_TOTAL)+PAGE_OFF_W-1:0] bs_addr,
	input wire logic [7:0] bs_wdata,
	output logic [7:0] bs_rdata
);
	localparam int FW = $clog2(NUM_FRAMES_TOTAL);
	localparam int PT_DEPTH = NUM_PROCESSES * PAGES;
	localparam int BS_DEPTH = NUM_FRAMES_TOTAL << PAGE_OFF_W;

	logic [FW+3:0] pt_mem [PT_DEPTH];
	logic [2:0] fo_mem [NUM_FRAMES_TOTAL];
	logic [7:0] bs_mem [BS_DEPTH];

	always_ff @(posedge clk) begin
		if (we.pt_we) begin
			pt_mem[pt_addr] <= pt_wdata;
		end
		pt_rdata <= pt_mem[pt_addr];
	end

	always_ff @(posedge clk) begin
		if (we.fo_we) begin
			fo_mem[fo_addr] <= fo_wdata;
		end
		fo_rdata <= fo_mem[fo_addr];
	end

	always_ff @(posedge clk) begin
		if (we.bs_we) begin
			bs_mem[bs_addr] <= bs_wdata;
		end
		bs_rdata <= bs_mem[bs_addr];
	end
endmodule
`default_nettype wire

@@ rtl/pmu_seq.sv @@
// Command sequencer with the shared counter and compare unit.
`default_nettype none
module pmu_seq import pmu_pkg::*; #(
	parameter int NUM_FRAMES_TOTAL = NUM_FRAMES_DEF,
	parameter int NUM_PROCESSES = NUM_PROC_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [2:0] cmd,
	input wire logic [2:0] pid,
	input wire logic [21:0] vaddr,
	input wire logic [7:0] wdata,
	input wire logic [10:0] page_count,
	input wire logic [2:0] flags,
	input wire logic [6:0] first_frame,
	output logic done,
	output logic [7:0] rdata,
	output logic fault,
	output mem_we_t we,
	output logic [$clog2(NUM_PROCESSES)+PAGE_NUM_W-1:0] pt_addr,
	output logic [$clog2(NUM_FRAMES_TOTAL)+3:0] pt_wdata,
	input wire logic [$clog2(NUM_FRAMES_TOTAL)+3:0] pt_rdata,
	output logic [$clog2(NUM_FRAMES_TOTAL)-1:0] fo_addr,
	output logic [2:0] fo_wdata,
	input wire logic [2:0] fo_rdata,
	output logic [$clog2(NUM_FRAMES_TOTAL)+PAGE_OFF_W-1:0] bs_addr,
	output logic [7:0] bs_wdata,
	input wire logic [7:0] bs_rdata
);
	localparam int FW = $clog2(NUM_FRAMES_TOTAL);
	localparam int PIDW = $clog2(NUM_PROCESSES);
	localparam int PTAW = PIDW + PAGE_NUM_W;
	localparam int BAW = FW + PAGE_OFF_W;
	localparam int CW = (FW + 1 > 7) ? FW + 1 : 7;
	localparam int PT_DEPTH = NUM_PROCESSES * PAGES;
	localparam int BS_DEPTH = NUM_FRAMES_TOTAL << PAGE_OFF_W;
	localparam int CLRN = (BS_DEPTH > PT_DEPTH) ? BS_DEPTH : PT_DEPTH;
	localparam int CLW = $clog2(CLRN);

	localparam logic [3:0] S_CLR = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_ISSUE = 4'd2;
	localparam logic [3:0] S_LOOK = 4'd3;
	localparam logic [3:0] S_BRD = 4'd4;
	localparam logic [3:0] S_A_LOOP = 4'd5;
	localparam logic [3:0] S_A_PTE = 4'd6;
	localparam logic [3:0] S_A_SCAN = 4'd7;
	localparam logic [3:0] S_A_OWN = 4'd8;
	localparam logic [3:0] S_D_LOOP = 4'd9;
	localparam logic [3:0] S_D_PTE = 4'd10;
	localparam logic [3:0] S_D_OWN = 4'd11;
	localparam logic [3:0] S_T_PT = 4'd12;
	localparam logic [3:0] S_T_FOR = 4'd13;
	localparam logic [3:0] S_T_FOC = 4'd14;
	localparam logic [3:0] S_FIN = 4'd15;

	logic [3:0] state_q, state_d;
	logic [2:0] cmd_q;
	logic [2:0] pid_q;
	logic [PAGE_NUM_W-1:0] page_q;
	logic [PAGE_OFF_W-1:0] off_q;
	logic [7:0] wdata_q;
	logic [10:0] cnt_q;
	logic [2:0] flags_q;
	logic [10:0] n_q, n_d;
	logic [10:0] p_q, p_d;
	logic [CW-1:0] cand_q, cand_d;
	logic [FW+3:0] pte_q, pte_d;
	logic [CLW-1:0] clr_q;
	logic res_fault_q, res_fault_d;
	logic [7:0] res_rd_q, res_rd_d;
	logic done_q;
	logic [7:0] rdata_q;
	logic fault_q;
	logic [PIDW+2:0] pid_wide;
	logic [PIDW-1:0] pid_idx;
	logic [FW:0] pt_frame;
	logic cand_over;
	logic pid_ok;

	assign pid_wide = {{PIDW{1'b0}}, pid_q};
	assign pid_idx = pid_wide[PIDW-1:0];
	assign pt_frame = {1'b0, pt_rdata[FW+3:4]};
	assign cand_over = cand_q >= CW'(NUM_FRAMES_TOTAL);
	assign pid_ok = (pid != 3'd0) && ({{PIDW{1'b0}}, pid} < (PIDW+3)'(NUM_PROCESSES));

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rdata = rdata_q;
	assign fault = fault_q;

	always_comb begin
		state_d = state_q;
		n_d = n_q;
		p_d = p_q;
		cand_d = cand_q;
		pte_d = pte_q;
		res_fault_d = res_fault_q;
		res_rd_d = res_rd_q;
		we = '0;
		pt_addr = {pid_idx, p_q[PAGE_NUM_W-1:0]};
		pt_wdata = '0;
		fo_addr = cand_q[FW-1:0];
		fo_wdata = 3'd0;
		bs_addr = {pte_q[FW+3:4], off_q};
		bs_wdata = wdata_q;
		unique case (state_q)
			S_CLR: begin
				pt_addr = clr_q[PTAW-1:0];
				bs_addr = clr_q[BAW-1:0];
				fo_addr = clr_q[FW-1:0];
				bs_wdata = 8'd0;
				we.pt_we = {1'b0, clr_q} < (CLW+1)'(PT_DEPTH);
				we.bs_we = {1'b0, clr_q} < (CLW+1)'(BS_DEPTH);
				we.fo_we = {1'b0, clr_q} < (CLW+1)'(NUM_FRAMES_TOTAL);
				if (clr_q == CLW'(CLRN - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					res_fault_d = 1'b0;
					res_rd_d = 8'd0;
					state_d = (pid_ok && (cmd <= CMD_EXIT)) ? S_ISSUE : S_FIN;
				end
			end
			S_ISSUE: begin
				pt_addr = {pid_idx, page_q};
				n_d = 11'd0;
				p_d = {1'b0, page_q};
				cand_d = CW'(first_frame);
				res_fault_d = 1'b0;
				res_rd_d = 8'd0;
				unique case (cmd_q)
					CMD_READ, CMD_WRITE: state_d = S_LOOK;
					CMD_ALLOC: state_d = S_A_LOOP;
					CMD_DEALLOC: state_d = S_D_LOOP;
					default: state_d = S_T_PT;
				endcase
			end
			S_LOOK: begin
				pte_d = pt_rdata;
				bs_addr = {pt_rdata[FW+3:4], off_q};
				if (!pt_rdata[PTE_PRESENT_BIT] || pt_frame >= (FW+1)'(NUM_FRAMES_TOTAL)
						|| (cmd_q == CMD_WRITE && !pt_rdata[PTE_WRITE_BIT])) begin
					res_fault_d = 1'b1;
					res_rd_d = (cmd_q == CMD_READ) ? RD_FAULT_BYTE : 8'd0;
					n_d = 11'd0;
					state_d = S_T_PT;
				end else if (cmd_q == CMD_WRITE) begin
					we.bs_we = 1'b1;
					state_d = S_FIN;
				end else begin
					state_d = S_BRD;
				end
			end
			S_BRD: begin
				res_rd_d = bs_rdata;
				state_d = S_FIN;
			end
			S_A_LOOP: begin
				if (n_q == cnt_q) begin
					state_d = S_FIN;
				end else if (p_q[PAGE_NUM_W]) begin
					res_fault_d = 1'b1;
					n_d = 11'd0;
					state_d = S_T_PT;
				end else begin
					state_d = S_A_PTE;
				end
			end
			S_A_PTE: begin
				if (pt_rdata[PTE_PRESENT_BIT]) begin
					res_fault_d = 1'b1;
					n_d = 11'd0;
					state_d = S_T_PT;
				end else begin
					state_d = S_A_SCAN;
				end
			end
			S_A_SCAN: begin
				if (cand_over) begin
					res_fault_d = 1'b1;
					n_d = 11'd0;
					state_d = S_T_PT;
				end else begin
					state_d = S_A_OWN;
				end
			end
			S_A_OWN: begin
				if (fo_rdata != 3'd0) begin
					cand_d = cand_q + CW'(1);
					state_d = S_A_SCAN;
				end else begin
					we.fo_we = 1'b1;
					we.pt_we = 1'b1;
					fo_wdata = pid_q;
					pt_wdata = {cand_q[FW-1:0], 1'b1, flags_q};
					n_d = n_q + 11'd1;
					p_d = p_q + 11'd1;
					state_d = S_A_LOOP;
				end
			end
			S_D_LOOP: begin
				if (n_q == cnt_q) begin
					state_d = S_FIN;
				end else if (p_q[PAGE_NUM_W]) begin
					res_fault_d = 1'b1;
					n_d = 11'd0;
					state_d = S_T_PT;
				end else begin
					state_d = S_D_PTE;
				end
			end
			S_D_PTE: begin
				pte_d = pt_rdata;
				fo_addr = pt_rdata[FW+3:4];
				if (!pt_rdata[PTE_PRESENT_BIT]
						|| pt_frame >= (FW+1)'(NUM_FRAMES_TOTAL)) begin
					res_fault_d = 1'b1;
					n_d = 11'd0;
					state_d = S_T_PT;
				end else begin
					state_d = S_D_OWN;
				end
			end
			S_D_OWN: begin
				fo_addr = pte_q[FW+3:4];
				if (fo_rdata != pid_q) begin
					res_fault_d = 1'b1;
					n_d = 11'd0;
					state_d = S_T_PT;
				end else begin
					we.fo_we = 1'b1;
					we.pt_we = 1'b1;
					n_d = n_q + 11'd1;
					p_d = p_q + 11'd1;
					state_d = S_D_LOOP;
				end
			end
			S_T_PT: begin
				pt_addr = {pid_idx, n_q[PAGE_NUM_W-1:0]};
				we.pt_we = 1'b1;
				n_d = n_q + 11'd1;
				if (n_q[PAGE_NUM_W-1:0] == PAGE_NUM_W'(PAGES - 1)) begin
					cand_d = '0;
					state_d = S_T_FOR;
				end
			end
			S_T_FOR: begin
				if (cand_over) begin
					state_d = S_FIN;
				end else begin
					state_d = S_T_FOC;
				end
			end
			S_T_FOC: begin
				we.fo_we = (fo_rdata == pid_q);
				cand_d = cand_q + CW'(1);
				state_d = S_T_FOR;
			end
			S_FIN: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= (state_q == S_FIN);
			if (state_q == S_CLR) begin
				clr_q <= clr_q + CLW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		n_q <= n_d;
		p_q <= p_d;
		cand_q <= cand_d;
		pte_q <= pte_d;
		res_fault_q <= res_fault_d;
		res_rd_q <= res_rd_d;
		if (state_q == S_IDLE && start) begin
			cmd_q <= cmd;
			pid_q <= pid;
			page_q <= vaddr[PAGE_OFF_W+PAGE_NUM_W-1:PAGE_OFF_W];
			off_q <= vaddr[PAGE_OFF_W-1:0];
			wdata_q <= wdata;
			cnt_q <= page_count;
			flags_q <= flags;
		end
		if (state_q == S_FIN) begin
			rdata_q <= res_rd_q;
			fault_q <= res_fault_q;
		end
	end

`ifndef ASSERT_OFF
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == S_IDLE) else $error("Result shown while the sequencer is active.");
	a_rd_fault: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && fault_q && cmd_q == CMD_READ |-> rdata_q == RD_FAULT_BYTE)
		else $error("A faulting read returned the wrong byte.");
	a_clr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLR |=> !done_q) else $error("Result shown during the clearing pass.");
	a_alloc_owner: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_A_OWN && we.fo_we |-> !cand_over && fo_wdata == pid_q)
		else $error("Allocation wrote an invalid frame owner.");
`endif
endmodule
`default_nettype wire
